// ===== sv/page_frame_bitmap_allocator_macros.svh =====
// ---------------------------------------------------------------------------
// Page frame bitmap allocator assertion macros
// Shared concurrent assertion forms for the allocator's checker.
// ---------------------------------------------------------------------------
`ifndef PAGE_FRAME_BITMAP_ALLOCATOR_MACROS_SVH
`define PAGE_FRAME_BITMAP_ALLOCATOR_MACROS_SVH

// Same-cycle implication, masked while reset is high
`define PFBA_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, masked while reset is high
`define PFBA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset
`define PFBA_ASSERT_RST(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/pfba_pkg.sv =====
// ---------------------------------------------------------------------------
// Page frame bitmap allocator package
// Shared constants, codes and types of the allocator.
// ---------------------------------------------------------------------------
`default_nettype none

package pfba_pkg;

   // Geometry of the bitmap and of a frame
   localparam int BITMAP_WORDS_DEFAULT = 1024;
   localparam int WORD_W               = 32;
   localparam int BIT_W                = 5;
   localparam int FRAME_SHIFT          = 12;
   localparam int ADDR_W               = 32;
   localparam int WORD_IDX_W           = ADDR_W - FRAME_SHIFT - BIT_W;
   localparam int WORDS_REG_W          = 11;

   // Request modes
   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   // Result status codes
   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_NOFREE = 2'd1;
   localparam logic [1:0] STATUS_RANGE  = 2'd2;

   // Register map (word index, byte address bit 2)
   localparam logic REG_REGION_BASE  = 1'b0;
   localparam logic REG_WORDS_IN_USE = 1'b1;

   // Bit unit operations
   typedef enum logic {
      OP_SET_LOWEST,
      OP_CLEAR
   } bit_op_type;

   // Bit unit result
   typedef struct packed {
      logic              has_clear;
      logic [BIT_W-1:0]  bit_idx;
      logic [WORD_W-1:0] word;
      logic              now_full;
   } bit_res_type;

endpackage

`default_nettype wire

// ===== sv/pfba_ram.sv =====
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module pfba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                                  clock,
   input  wire logic                                  wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                      wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/pfba_bit_unit.sv =====
// ---------------------------------------------------------------------------
// Bitmap word unit
// Finds and sets the lowest clear bit of a word, or clears a given bit.
// ---------------------------------------------------------------------------
`default_nettype none

module pfba_bit_unit (
   input  wire logic [pfba_pkg::WORD_W-1:0] word_i,
   input  wire pfba_pkg::bit_op_type        op_i,
   input  wire logic [pfba_pkg::BIT_W-1:0]  bit_i,
   output pfba_pkg::bit_res_type            res_o
);

   logic [pfba_pkg::BIT_W-1:0]  sel_bit;
   logic [pfba_pkg::WORD_W-1:0] mask;
   logic                        found;
   logic [pfba_pkg::BIT_W-1:0]  low_bit;

   // Priority search for the lowest clear bit
   always_comb begin
      found   = 1'b0;
      low_bit = '0;
      for (int i = pfba_pkg::WORD_W - 1; i >= 0; i--) begin
         if (!word_i[i]) begin
            found   = 1'b1;
            low_bit = pfba_pkg::BIT_W'(i);
         end
      end
   end

   // Set or clear one bit
   always_comb begin
      case (op_i)
         pfba_pkg::OP_SET_LOWEST: sel_bit = low_bit;
         pfba_pkg::OP_CLEAR:      sel_bit = bit_i;
         default:                 sel_bit = bit_i;
      endcase
      mask = pfba_pkg::WORD_W'(1) << sel_bit;
      res_o.has_clear = found;
      res_o.bit_idx   = low_bit;
      case (op_i)
         pfba_pkg::OP_SET_LOWEST: res_o.word = word_i | mask;
         pfba_pkg::OP_CLEAR:      res_o.word = word_i & ~mask;
         default:                 res_o.word = word_i;
      endcase
      res_o.now_full = &res_o.word;
   end

endmodule

`default_nettype wire

// ===== sv/page_frame_bitmap_allocator.sv =====
// ---------------------------------------------------------------------------
// Page frame bitmap allocator
// Bitmap of 4 KiB frames in a RAM, one bit per frame; allocate takes the
// lowest clear bit of the first non-full word, free clears a frame's bit.
// ---------------------------------------------------------------------------
// Steps: free runs FREE_CHK, FREE_WR, RESULT (FREE_CHK to RESULT when out of
// range); allocate runs ALLOC_RD, ALLOC_EVAL per word from the hint on, then
// RESULT (from ALLOC_RD when no frame is free). One item at a time: the next is
// taken in the cycle after the result loads; RESULT waits while the output is stalled.
// Reset: control registers clear, then a clearing pass writes BITMAP_WORDS RAM
// words, one a cycle, while req_stall stays high.
`default_nettype none

module page_frame_bitmap_allocator #(
   parameter int BITMAP_WORDS = pfba_pkg::BITMAP_WORDS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_mode,
   input  wire logic [31:0] req_page_address,
   // result channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_address,
   output logic [1:0]       rsp_status,
   // configuration port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int AW = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
   localparam int CW = $clog2(BITMAP_WORDS + 1);
   localparam int NW = (CW > pfba_pkg::WORDS_REG_W) ? CW : pfba_pkg::WORDS_REG_W;
   localparam int PW = (NW > pfba_pkg::WORD_IDX_W) ? NW : pfba_pkg::WORD_IDX_W;
   localparam logic [CW-1:0] LAST_WORD = CW'(BITMAP_WORDS - 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ALLOC_RD,
      ST_ALLOC_EVAL,
      ST_FREE_CHK,
      ST_FREE_WR,
      ST_RESULT
   } state_type;

   state_type                          state_ff, state_in;
   logic [CW-1:0]                      ptr_ff, ptr_in;
   logic [CW-1:0]                      hint_ff, hint_in;
   logic [pfba_pkg::BIT_W-1:0]         bit_ff, bit_in;
   logic [31:0]                        page_addr_ff, page_addr_in;
   logic [31:0]                        res_addr_ff, res_addr_in;
   logic [1:0]                         res_status_ff, res_status_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [31:0]                        rsp_address_ff, rsp_address_in;
   logic [1:0]                         rsp_status_ff, rsp_status_in;
   logic [31:0]                        region_base_ff;
   logic [pfba_pkg::WORDS_REG_W-1:0]   words_in_use_ff;

   logic                               ram_we;
   logic [AW-1:0]                      ram_wa;
   logic [pfba_pkg::WORD_W-1:0]        ram_wd;
   logic [AW-1:0]                      ram_ra;
   logic [pfba_pkg::WORD_W-1:0]        ram_rd;

   pfba_pkg::bit_op_type               bop;
   pfba_pkg::bit_res_type              bit_res;

   logic [NW-1:0]                      words_wide;
   logic [NW-1:0]                      n_words;
   logic [31:0]                        free_diff;
   logic                               free_below;
   logic [pfba_pkg::WORD_IDX_W-1:0]    free_word;
   logic [pfba_pkg::BIT_W-1:0]         free_bit;
   logic                               free_beyond;
   logic [CW-1:0]                      free_word_c;
   logic [31:0]                        alloc_offset;
   logic                               csr_wr;

   // Bitmap storage
   pfba_ram #(
      .WIDTH (pfba_pkg::WORD_W),
      .DEPTH (BITMAP_WORDS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   // Shared bit search / update unit
   pfba_bit_unit u_bit (
      .word_i (ram_rd),
      .op_i   (bop),
      .bit_i  (bit_ff),
      .res_o  (bit_res)
   );

   // Clamp the word count to the storage depth
   assign words_wide = NW'(words_in_use_ff);
   assign n_words    = (words_wide > NW'(BITMAP_WORDS)) ? NW'(BITMAP_WORDS) : words_wide;

   // Free address decode
   assign free_diff   = page_addr_ff - region_base_ff;
   assign free_below  = page_addr_ff < region_base_ff;
   assign free_word   = free_diff[31:pfba_pkg::FRAME_SHIFT + pfba_pkg::BIT_W];
   assign free_bit    = free_diff[pfba_pkg::FRAME_SHIFT +: pfba_pkg::BIT_W];
   assign free_beyond = PW'(free_word) >= PW'(n_words);
   assign free_word_c = CW'(free_word);

   // Byte offset of the frame found by the scan
   assign alloc_offset = 32'({ptr_ff[AW-1:0], bit_res.bit_idx,
                              {pfba_pkg::FRAME_SHIFT{1'b0}}});

   // Sequencer
   always_comb begin
      state_in       = state_ff;
      ptr_in         = ptr_ff;
      hint_in        = hint_ff;
      bit_in         = bit_ff;
      page_addr_in   = page_addr_ff;
      res_addr_in    = res_addr_ff;
      res_status_in  = res_status_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_address_in = rsp_address_ff;
      rsp_status_in  = rsp_status_ff;
      ram_we         = 1'b0;
      ram_wa         = ptr_ff[AW-1:0];
      ram_wd         = '0;
      ram_ra         = ptr_ff[AW-1:0];
      bop            = pfba_pkg::OP_SET_LOWEST;

      // drop the result word once taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
            if (ptr_ff == LAST_WORD) begin
               ptr_in   = '0;
               state_in = ST_IDLE;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               page_addr_in = req_page_address;
               if (req_mode == pfba_pkg::MODE_FREE) begin
                  state_in = ST_FREE_CHK;
               end else begin
                  ptr_in   = hint_ff;
                  state_in = ST_ALLOC_RD;
               end
            end
         end
         ST_ALLOC_RD: begin
            // words below the pointer are all full
            if (NW'(ptr_ff) >= n_words) begin
               res_status_in = pfba_pkg::STATUS_NOFREE;
               res_addr_in   = '0;
               hint_in       = ptr_ff;
               state_in      = ST_RESULT;
            end else begin
               state_in = ST_ALLOC_EVAL;
            end
         end
         ST_ALLOC_EVAL: begin
            bop = pfba_pkg::OP_SET_LOWEST;
            if (bit_res.has_clear) begin
               ram_we        = 1'b1;
               ram_wd        = bit_res.word;
               res_addr_in   = region_base_ff + alloc_offset;
               res_status_in = pfba_pkg::STATUS_OK;
               hint_in       = bit_res.now_full ? ptr_ff + 1'b1 : ptr_ff;
               state_in      = ST_RESULT;
            end else begin
               ptr_in   = ptr_ff + 1'b1;
               state_in = ST_ALLOC_RD;
            end
         end
         ST_FREE_CHK: begin
            if (free_below || free_beyond) begin
               res_status_in = pfba_pkg::STATUS_RANGE;
               res_addr_in   = '0;
               state_in      = ST_RESULT;
            end else begin
               ram_ra   = AW'(free_word);
               ptr_in   = free_word_c;
               bit_in   = free_bit;
               if (free_word_c < hint_ff) begin
                  hint_in = free_word_c;
               end
               state_in = ST_FREE_WR;
            end
         end
         ST_FREE_WR: begin
            bop           = pfba_pkg::OP_CLEAR;
            ram_we        = 1'b1;
            ram_wd        = bit_res.word;
            res_status_in = pfba_pkg::STATUS_OK;
            res_addr_in   = '0;
            state_in      = ST_RESULT;
         end
         ST_RESULT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_address_in = res_addr_ff;
               rsp_status_in  = res_status_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // State, working and output registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         ptr_ff          <= '0;
         hint_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
         region_base_ff  <= '0;
         words_in_use_ff <= '0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         hint_ff      <= hint_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr) begin
            case (csr_paddr[2])
               pfba_pkg::REG_REGION_BASE:  region_base_ff  <= csr_pwdata;
               pfba_pkg::REG_WORDS_IN_USE: words_in_use_ff <=
                  csr_pwdata[pfba_pkg::WORDS_REG_W-1:0];
               default: ;
            endcase
         end
      end
      bit_ff         <= bit_in;
      page_addr_ff   <= page_addr_in;
      res_addr_ff    <= res_addr_in;
      res_status_ff  <= res_status_in;
      rsp_address_ff <= rsp_address_in;
      rsp_status_ff  <= rsp_status_in;
   end

   // Register read back
   always_comb begin
      case (csr_paddr[2])
         pfba_pkg::REG_REGION_BASE:  csr_prdata = region_base_ff;
         pfba_pkg::REG_WORDS_IN_USE: csr_prdata = 32'(words_in_use_ff);
         default:                    csr_prdata = '0;
      endcase
   end

   assign csr_pready  = 1'b1;
   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_address = rsp_address_ff;
   assign rsp_status  = rsp_status_ff;

endmodule

`default_nettype wire

// ===== sv/pfba_checker.sv =====
// ---------------------------------------------------------------------------
// Page frame bitmap allocator checker
// Port-level assertions, bound to the allocator's top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "page_frame_bitmap_allocator_macros.svh"

module pfba_assert_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [31:0] rsp_address,
   input wire logic [1:0]  rsp_status
);

   logic [34:0] rsp_word;
   logic        rsp_blocked;
   logic        rsp_failed;
   logic        status_known;

   // Result word as seen on the port
   assign rsp_word     = {rsp_valid, rsp_address, rsp_status};
   assign rsp_blocked  = rsp_valid && rsp_stall;
   assign rsp_failed   = rsp_valid && (rsp_status != pfba_pkg::STATUS_OK);
   assign status_known = (rsp_status == pfba_pkg::STATUS_OK) ||
                         (rsp_status == pfba_pkg::STATUS_NOFREE) ||
                         (rsp_status == pfba_pkg::STATUS_RANGE);

   // Hold a stalled result word
   `PFBA_ASSERT_NEXT(a_hold, clock, reset, rsp_blocked, $stable(rsp_word), "stalled word moved")

   // Status is one of the defined codes
   `PFBA_ASSERT_SAME(a_code, clock, reset, rsp_valid, status_known, "bad status code")

   // Failed requests carry a zero address
   `PFBA_ASSERT_SAME(a_zero, clock, reset, rsp_failed, ~|rsp_address, "address on failure")

   // Reset empties the output and starts the clearing pass
   `PFBA_ASSERT_RST(a_reset_state, clock, reset, !rsp_valid && req_stall, "not idle after reset")

endmodule

bind page_frame_bitmap_allocator pfba_assert_checker u_pfba_checker (.*);

`default_nettype wire

// ===== bench/pfba_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Page frame allocator checker
// Watches the request, result and register ports of the allocator, keeps
// its own frame bitmap and region settings, and compares every result word
// with the answer that the bitmap gives for the matching request word.
// ---------------------------------------------------------------------------

module pfba_checker #(
   parameter int MAP_WORDS = pfba_pkg::BITMAP_WORDS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic        req_mode,
   input  wire logic [31:0] req_page_address,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [31:0] rsp_address,
   input  wire logic [1:0]  rsp_status,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   input  wire logic        csr_pready,
   output int unsigned      in_flight,
   output int unsigned      fail_count
);

   typedef struct packed {
      logic [31:0] address;
      logic [1:0]  status;
   } frame_answer_type;

   // Frame bitmap and region settings as the allocator should hold them
   logic [31:0]      frame_map [MAP_WORDS];
   logic [31:0]      base_reg;
   logic [10:0]      words_reg;
   frame_answer_type answers_due [$];

   // Grant or release one frame and return the answer the allocator owes
   function automatic frame_answer_type frame_request(input logic        mode,
                                                      input logic [31:0] page_address);
      frame_answer_type ans;
      int unsigned      span;
      int unsigned      w;
      int unsigned      b;
      logic [31:0]      page;
      bit               found;
      ans.address = '0;
      ans.status  = pfba_pkg::STATUS_OK;
      span  = (words_reg > MAP_WORDS) ? MAP_WORDS : words_reg;
      found = 1'b0;
      if (mode == pfba_pkg::MODE_ALLOC) begin
         // scan for the first word with a clear bit, take its lowest one
         for (w = 0; w < span && !found; w++) begin
            if (frame_map[w] != 32'hFFFF_FFFF) begin
               for (b = 0; b < 32 && !found; b++) begin
                  if (!frame_map[w][b]) begin
                     frame_map[w][b] = 1'b1;
                     page        = w * 32 + b;
                     ans.address = base_reg + (page << pfba_pkg::FRAME_SHIFT);
                     found       = 1'b1;
                  end
               end
            end
         end
         if (!found) ans.status = pfba_pkg::STATUS_NOFREE;
      end else begin
         page = (page_address - base_reg) >> pfba_pkg::FRAME_SHIFT;
         if (page_address < base_reg || page >= span * 32) begin
            ans.status = pfba_pkg::STATUS_RANGE;
         end else begin
            frame_map[page >> 5][page[4:0]] = 1'b0;
         end
      end
      return ans;
   endfunction

   always @(posedge clock) begin
      frame_answer_type want;
      if (reset) begin
         // clear the bitmap and the registers, drop anything outstanding
         for (int i = 0; i < MAP_WORDS; i++) frame_map[i] = '0;
         base_reg  = '0;
         words_reg = '0;
         answers_due.delete();
         fail_count = 0;
      end else begin
         // track register writes
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[2])
               pfba_pkg::REG_REGION_BASE:  base_reg  = csr_pwdata;
               pfba_pkg::REG_WORDS_IN_USE: words_reg = csr_pwdata[10:0];
               default: ;
            endcase
         end
         // predict each accepted request word
         if (req_valid && !req_stall) begin
            answers_due.push_back(frame_request(req_mode, req_page_address));
         end
         // compare each accepted result word with the oldest answer
         if (rsp_valid && !rsp_stall) begin
            if (answers_due.size() == 0) begin
               $display("%0t: result with nothing outstanding: address %h status %0d",
                        $time, rsp_address, rsp_status);
               fail_count++;
            end else begin
               want = answers_due.pop_front();
               if (rsp_address !== want.address) begin
                  $display("%0t: address mismatch: expected %h, actual %h",
                           $time, want.address, rsp_address);
                  fail_count++;
               end
               if (rsp_status !== want.status) begin
                  $display("%0t: status mismatch: expected %0d, actual %0d",
                           $time, want.status, rsp_status);
                  fail_count++;
               end
            end
         end
      end
      in_flight = answers_due.size();
   end

endmodule

// ===== bench/tb_page_frame_bitmap_allocator.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Page frame allocator testbench
// Drives allocate and free words through the allocator under several region
// settings and idle patterns; the checker beside it predicts every result.
// ---------------------------------------------------------------------------

module tb_page_frame_bitmap_allocator;

   localparam int MAP_WORDS   = pfba_pkg::BITMAP_WORDS_DEFAULT;
   localparam int QUIET_LIMIT = 20000;
   localparam int TAIL_CYCLES = 20;

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_stall;
   logic        req_mode         = pfba_pkg::MODE_ALLOC;
   logic [31:0] req_page_address = '0;
   logic        rsp_valid;
   logic        rsp_stall        = 1'b0;
   logic [31:0] rsp_address;
   logic [1:0]  rsp_status;
   logic        csr_psel         = 1'b0;
   logic        csr_penable      = 1'b0;
   logic        csr_pwrite       = 1'b0;
   logic [2:0]  csr_paddr        = '0;
   logic [31:0] csr_pwdata       = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int unsigned in_flight;
   int unsigned fail_count;
   int unsigned quiet_cycles = 0;
   int          send_idle    = 0;
   int          take_idle    = 0;
   logic [31:0] cur_base     = '0;
   logic [10:0] cur_words    = '0;

   page_frame_bitmap_allocator uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_page_address (req_page_address),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_address      (rsp_address),
      .rsp_status       (rsp_status),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   pfba_checker #(.MAP_WORDS(MAP_WORDS)) chk (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_page_address (req_page_address),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_address      (rsp_address),
      .rsp_status       (rsp_status),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_pready       (csr_pready),
      .in_flight        (in_flight),
      .fail_count       (fail_count)
   );

   always #2 clock = ~clock;

   // Stall the result side at random
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < take_idle);
   end

   // End the run when no word moves for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Present one request word, with random idle cycles ahead of it
   task automatic send_word(input logic mode, input logic [31:0] address);
      while ($urandom_range(0, 99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_mode         <= mode;
      req_page_address <= address;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Hold off until every outstanding result word has come back
   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (in_flight != 0);
      @(posedge clock);
   endtask

   // One register write: setup cycle, then access until pready
   task automatic write_reg(input logic index, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
   endtask

   task automatic configure(input logic [31:0] base, input logic [10:0] words);
      drain();
      write_reg(pfba_pkg::REG_REGION_BASE, base);
      write_reg(pfba_pkg::REG_WORDS_IN_USE, {21'd0, words});
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      cur_base  = base;
      cur_words = words;
   endtask

   // Random allocations mixed with mostly well-formed frees, biased to low frames, plus out-of-range noise
   task automatic run_segment(input int count, input int alloc_pct);
      int unsigned span;
      int unsigned page;
      int          pick;
      logic [31:0] address;
      span = ((cur_words > MAP_WORDS) ? MAP_WORDS : cur_words) * 32;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < alloc_pct) begin
            send_word(pfba_pkg::MODE_ALLOC, $urandom());
         end else begin
            pick = $urandom_range(0, 9);
            if (span == 0 || pick == 0) begin
               address = $urandom();
            end else if (pick == 1) begin
               if (cur_base != 0 && $urandom_range(0, 1) == 1)
                  address = cur_base - $urandom_range(1, 4096);
               else
                  address = cur_base + (span << 12) + $urandom_range(0, 4095);
            end else begin
               page = (pick < 8 && span > 64) ? $urandom_range(0, 63)
                                              : $urandom_range(0, span - 1);
               address = cur_base + (page << 12) + $urandom_range(0, 4095);
            end
            send_word(pfba_pkg::MODE_FREE, address);
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      send_idle = 25;
      take_idle = 54;

      // no words in use straight after reset
      send_word(pfba_pkg::MODE_ALLOC, 32'h0000_0000);
      send_word(pfba_pkg::MODE_FREE,  32'h0000_0000);

      // top-of-memory base: second grant wraps to zero
      configure(32'hFFFF_F000, 11'd1);
      send_word(pfba_pkg::MODE_ALLOC, 32'hFFFF_FFFF);
      send_word(pfba_pkg::MODE_ALLOC, 32'h0000_0000);
      send_word(pfba_pkg::MODE_FREE,  32'h0000_0000);
      send_word(pfba_pkg::MODE_FREE,  32'hFFFF_FFFF);
      send_word(pfba_pkg::MODE_FREE,  32'hFFFF_FFFF);
      send_word(pfba_pkg::MODE_ALLOC, 32'h0000_0000);

      // unaligned base: below base, inside a frame, past the region
      configure(32'h1234_5678, 11'd1);
      send_word(pfba_pkg::MODE_ALLOC, 32'h0000_0000);
      send_word(pfba_pkg::MODE_FREE,  32'h1234_5677);
      send_word(pfba_pkg::MODE_FREE,  32'h1234_7677);
      send_word(pfba_pkg::MODE_FREE,  32'h1234_5678 + (32 << 12));

      // region shrunk to nothing
      configure(32'h1234_5678, 11'd0);
      send_word(pfba_pkg::MODE_ALLOC, 32'h0000_0000);
      send_word(pfba_pkg::MODE_FREE,  32'h1234_5678);

      // word count above the bitmap size is clipped
      configure(32'h0000_0000, 11'd2047);
      send_word(pfba_pkg::MODE_FREE,  32'h7FFF_FFFF);
      send_word(pfba_pkg::MODE_FREE,  32'h07FF_F000);
      send_word(pfba_pkg::MODE_FREE,  32'h0800_0000);
      send_word(pfba_pkg::MODE_ALLOC, 32'h0000_0000);

      // random traffic, sender idles less than receiver
      configure($urandom() & 32'hFFFF_F000, 11'd1);
      run_segment(67, 70);
      configure($urandom(), 11'd2);
      run_segment(67, 60);

      // receiver idles less than sender
      send_idle = 54;
      take_idle = 25;
      configure(32'hFFFF_0000, 11'd3);
      run_segment(67, 60);
      configure(32'h0000_0000, 11'd1024);
      run_segment(67, 55);

      // no idling on either side
      send_idle = 0;
      take_idle = 0;
      configure($urandom(), 11'd2047);
      run_segment(67, 55);
      configure($urandom() & 32'hFFFF_F000, 11'($urandom_range(1, 4)));
      run_segment(67, 65);

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/pfba_pkg.sv
sv/pfba_ram.sv
sv/pfba_bit_unit.sv
sv/page_frame_bitmap_allocator.sv
sv/pfba_checker.sv
bench/pfba_checker.sv
bench/tb_page_frame_bitmap_allocator.sv
